[rtl/mfr_pkg.sv]
// Package for the message frame receiver: phase type, result kinds, result record.
`default_nettype none
package mfr_pkg;

	typedef enum logic [2:0] {
		PH_FIRST     = 3'd0,
		PH_PREFIX    = 3'd1,
		PH_WS_SECOND = 3'd2,
		PH_WS_EXT16  = 3'd3,
		PH_WS_EXT64  = 3'd4,
		PH_MASK      = 3'd5,
		PH_PAYLOAD   = 3'd6
	} phase_t;

	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_EMPTY   = 2'd2;
	localparam logic [1:0] KIND_ERROR   = 2'd3;

	localparam logic [1:0] MODE_SHORT = 2'd0;
	localparam logic [1:0] MODE_LONG  = 2'd1;

	localparam logic REG_FRAME_MODE = 1'b0;
	localparam logic REG_MAX_LENGTH = 1'b1;

	localparam logic [7:0] WS_OPCODE_TEXT = 8'h81;
	localparam logic [6:0] WS_LEN_EXT16   = 7'd126;
	localparam logic [6:0] WS_LEN_EXT64   = 7'd127;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  payload_byte;
		logic        last_of_message;
		logic [31:0] message_length;
	} result_t;

endpackage
`default_nettype wire

[rtl/mfr_parser.sv]
// Frame parser: header, length, mask and payload state with one result per byte.
`default_nettype none
module mfr_parser #(
	parameter int LENGTH_BITS = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire logic [7:0]       rx_byte,
	input  wire logic [1:0]       frame_mode,
	input  wire logic [23:0]      max_length,
	output mfr_pkg::result_t      result
);
	import mfr_pkg::*;

	phase_t                 phase_q, phase_n;
	logic [3:0]             cnt_q, cnt_n, cnt_inc;
	logic [31:0]            acc_q, acc_n, acc_shift;
	logic [7:0]             key_q [4];
	logic [7:0]             key_n [4];
	logic [LENGTH_BITS-1:0] rem_q, rem_n, rem_dec;
	logic [1:0]             idx_q, idx_n;
	logic                   do_begin, do_ws_done, over_limit;
	logic [3:0]             need;

	assign cnt_inc   = cnt_q + 4'd1;
	assign acc_shift = {acc_q[23:0], rx_byte};
	assign rem_dec   = rem_q - LENGTH_BITS'(1);
	assign need = (frame_mode == MODE_SHORT) ? 4'd2 : 4'd4;

	always_comb begin
		phase_n    = phase_q;
		cnt_n      = cnt_q;
		acc_n      = acc_q;
		key_n      = key_q;
		rem_n      = rem_q;
		idx_n      = idx_q;
		do_begin   = 1'b0;
		do_ws_done = 1'b0;
		result     = '0;
		result.kind = KIND_HEADER;

		case (phase_q)
			PH_PREFIX: begin
				acc_n = acc_shift;
				cnt_n = cnt_inc;
				if (cnt_inc >= need) begin
					if (|(acc_shift >> LENGTH_BITS)) begin
						phase_n     = PH_FIRST;
						cnt_n       = 4'd0;
						result.kind = KIND_ERROR;
					end else begin
						key_n    = '{default: 8'd0};
						do_begin = 1'b1;
					end
				end
			end
			PH_WS_SECOND: begin
				if (!rx_byte[7]) begin
					phase_n     = PH_FIRST;
					cnt_n       = 4'd0;
					result.kind = KIND_ERROR;
				end else begin
					cnt_n = 4'd0;
					acc_n = 32'd0;
					if (rx_byte[6:0] == WS_LEN_EXT16) begin
						phase_n = PH_WS_EXT16;
					end else if (rx_byte[6:0] == WS_LEN_EXT64) begin
						phase_n = PH_WS_EXT64;
					end else begin
						acc_n      = {25'd0, rx_byte[6:0]};
						do_ws_done = 1'b1;
					end
				end
			end
			PH_WS_EXT16: begin
				acc_n = {16'd0, acc_shift[15:0]};
				cnt_n = cnt_inc;
				do_ws_done = (cnt_inc >= 4'd2);
			end
			PH_WS_EXT64: begin
				if (cnt_q < 4'd4 && rx_byte != 8'd0) begin
					phase_n     = PH_FIRST;
					cnt_n       = 4'd0;
					result.kind = KIND_ERROR;
				end else begin
					if (cnt_q >= 4'd4) begin
						acc_n = acc_shift;
					end
					cnt_n      = cnt_inc;
					do_ws_done = (cnt_inc >= 4'd8);
				end
			end
			PH_MASK: begin
				key_n[cnt_q[1:0]] = rx_byte;
				cnt_n    = cnt_inc;
				do_begin = (cnt_inc >= 4'd4);
			end
			PH_PAYLOAD: begin
				idx_n = idx_q + 2'd1;
				rem_n = rem_dec;
				result.kind            = KIND_PAYLOAD;
				result.payload_byte    = rx_byte ^ key_q[idx_q];
				result.last_of_message = (rem_dec == '0);
				result.message_length  = acc_q;
				if (rem_dec == '0) begin
					phase_n = PH_FIRST;
					cnt_n   = 4'd0;
				end
			end
			default: begin
				cnt_n = 4'd0;
				if (frame_mode == MODE_SHORT || frame_mode == MODE_LONG) begin
					acc_n   = {24'd0, rx_byte};
					cnt_n   = 4'd1;
					phase_n = PH_PREFIX;
				end else if (rx_byte == WS_OPCODE_TEXT) begin
					phase_n = PH_WS_SECOND;
				end else begin
					phase_n     = PH_FIRST;
					result.kind = KIND_ERROR;
				end
			end
		endcase

		over_limit = |(acc_n >> LENGTH_BITS);

		if (do_ws_done) begin
			if (acc_n > {8'd0, max_length} || over_limit) begin
				phase_n     = PH_FIRST;
				cnt_n       = 4'd0;
				result.kind = KIND_ERROR;
			end else begin
				phase_n = PH_MASK;
				cnt_n   = 4'd0;
			end
		end

		if (do_begin) begin
			if (acc_n == 32'd0) begin
				phase_n     = PH_FIRST;
				cnt_n       = 4'd0;
				result.kind = KIND_EMPTY;
			end else begin
				rem_n   = acc_n[LENGTH_BITS-1:0];
				idx_n   = 2'd0;
				cnt_n   = 4'd0;
				phase_n = PH_PAYLOAD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			cnt_q   <= 4'd0;
			acc_q   <= 32'd0;
			key_q   <= '{default: 8'd0};
			rem_q   <= '0;
			idx_q   <= 2'd0;
		end else if (step) begin
			phase_q <= phase_n;
			cnt_q   <= cnt_n;
			acc_q   <= acc_n;
			key_q   <= key_n;
			rem_q   <= rem_n;
			idx_q   <= idx_n;
		end
	end

endmodule
`default_nettype wire

[rtl/message_frame_receiver.sv]
// Top level of the message frame receiver: ports, configuration, input and result stages.
//
//  Channel  Direction  Signals                          Contents
//  s_*      in         s_tvalid s_tready s_tdata[7:0]   received byte
//  m_*      out        m_tvalid m_tready m_tdata m_tuser m_tlast  one result per byte
//  cfg_*    in         cfg_wr_en cfg_index cfg_wdata    register writes
//
// Every byte produces exactly one result, and one byte is taken per clock cycle unless stalled.
// From the input transaction a byte passes through the input stage, then the result register.
// The parser state advances when the input stage moves into the result register.
// A stalled result register holds the input stage; the input accepts while that stage is
// empty or moving on.
// Reset returns the parser to waiting for the first header byte and restores the registers.
`default_nettype none
module message_frame_receiver #(
	parameter int LENGTH_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // [7:0] payload_byte, [39:8] message_length
	output logic [1:0]       m_tuser,   // [1:0] kind
	output logic             m_tlast,
	input  wire logic        cfg_wr_en,
	input  wire logic        cfg_index,
	input  wire logic [23:0] cfg_wdata
);
	import mfr_pkg::*;

	logic [1:0]  frame_mode_q;
	logic [23:0] max_length_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        valid_s2;
	result_t     result_s2;
	result_t     result;
	logic        out_free;
	logic        step;

	assign out_free = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || out_free;
	assign step     = valid_s1 && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_mode_q <= 2'd2;
			max_length_q <= 24'hffffff;
		end else if (cfg_wr_en) begin
			if (cfg_index == REG_FRAME_MODE) begin
				frame_mode_q <= cfg_wdata[1:0];
			end else if (cfg_index == REG_MAX_LENGTH) begin
				max_length_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (out_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
		if (step) begin
			result_s2 <= result;
		end
	end

	mfr_parser #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.rx_byte    (byte_s1),
		.frame_mode (frame_mode_q),
		.max_length (max_length_q),
		.result     (result)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {result_s2.message_length, result_s2.payload_byte};
	assign m_tuser  = result_s2.kind;
	assign m_tlast  = result_s2.last_of_message;

	a_last_only_payload: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser == KIND_PAYLOAD)
		else $error("last flag on a non-payload result");

	a_quiet_non_payload: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != KIND_PAYLOAD |-> m_tdata == 40'd0 && !m_tlast)
		else $error("non-payload result carries data");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |=> valid_s1 && $stable(byte_s1))
		else $error("input stage lost a byte under backpressure");

endmodule
`default_nettype wire

[verif/message_frame_receiver_tb.sv]
// Testbench for message_frame_receiver: directed and random byte streams checked against a predicted result stream.
`timescale 1ns / 100ps
module message_frame_receiver_tb;
	import mfr_pkg::*;

	localparam int LENGTH_BITS = 32;
	localparam longint unsigned LEN_LIMIT = (64'd1 << LENGTH_BITS) - 64'd1;
	localparam logic [1:0] MODE_WEBSOCKET = 2'd2;
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic [23:0] MAX_LENGTH_TOP = 24'hFF_FFFF;
	localparam logic [23:0] MAX_LENGTH_LOW = 24'd128;
	localparam logic [7:0] WS_LEN16_BYTE = 8'hFE;
	localparam logic [7:0] WS_LEN64_BYTE = 8'hFF;
	localparam int DRAIN_CYCLES = 4;
	localparam int CYCLE_LIMIT = 200000;
	localparam int REPORT_LIMIT = 100;

	logic clk;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [1:0] m_tuser;
	logic m_tlast;
	logic cfg_wr_en = 1'b0;
	logic cfg_index = REG_FRAME_MODE;
	logic [23:0] cfg_wdata = '0;

	message_frame_receiver #(
		.LENGTH_BITS(LENGTH_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	logic [1:0] mode_reg = MODE_WEBSOCKET;
	logic [23:0] max_len_reg = MAX_LENGTH_TOP;
	phase_t ph = PH_FIRST;
	logic [3:0] hdr_cnt = '0;
	logic [31:0] len_acc = '0;
	logic [3:0][7:0] mask_key = '0;
	logic [31:0] remain = '0;
	logic [1:0] mask_idx = '0;

	result_t deframed_q[$];
	logic [7:0] frame_q[$];
	bit idle_on = 1'b1;
	int holdoff_request = 0;
	int mismatch_count = 0;
	int cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void go_idle();
		ph = PH_FIRST;
		hdr_cnt = '0;
	endfunction

	function automatic result_t start_payload();
		result_t r;
		r = '0;
		if (len_acc == 32'd0) begin
			go_idle();
			r.kind = KIND_EMPTY;
		end else begin
			remain = len_acc;
			mask_idx = '0;
			hdr_cnt = '0;
			ph = PH_PAYLOAD;
			r.kind = KIND_HEADER;
		end
		return r;
	endfunction

	function automatic result_t check_ws_length();
		result_t r;
		r = '0;
		if (len_acc > {8'd0, max_len_reg} || {32'd0, len_acc} > LEN_LIMIT) begin
			go_idle();
			r.kind = KIND_ERROR;
		end else begin
			hdr_cnt = '0;
			ph = PH_MASK;
			r.kind = KIND_HEADER;
		end
		return r;
	endfunction

	function automatic result_t deframe_byte(input logic [7:0] b);
		result_t r;
		r = '0;
		r.kind = KIND_HEADER;
		case (ph)
			PH_PREFIX: begin
				len_acc = {len_acc[23:0], b};
				hdr_cnt = hdr_cnt + 4'd1;
				if (hdr_cnt >= ((mode_reg == MODE_SHORT) ? 4'd2 : 4'd4)) begin
					if ({32'd0, len_acc} > LEN_LIMIT) begin
						go_idle();
						r.kind = KIND_ERROR;
					end else begin
						mask_key = '0;
						r = start_payload();
					end
				end
			end
			PH_WS_SECOND: begin
				if (!b[7]) begin
					go_idle();
					r.kind = KIND_ERROR;
				end else begin
					hdr_cnt = '0;
					len_acc = '0;
					if (b[6:0] == WS_LEN_EXT16) begin
						ph = PH_WS_EXT16;
					end else if (b[6:0] == WS_LEN_EXT64) begin
						ph = PH_WS_EXT64;
					end else begin
						len_acc = {25'd0, b[6:0]};
						r = check_ws_length();
					end
				end
			end
			PH_WS_EXT16: begin
				len_acc = {16'd0, len_acc[7:0], b};
				hdr_cnt = hdr_cnt + 4'd1;
				if (hdr_cnt >= 4'd2)
					r = check_ws_length();
			end
			PH_WS_EXT64: begin
				if (hdr_cnt < 4'd4 && b != 8'd0) begin
					go_idle();
					r.kind = KIND_ERROR;
				end else begin
					if (hdr_cnt >= 4'd4)
						len_acc = {len_acc[23:0], b};
					hdr_cnt = hdr_cnt + 4'd1;
					if (hdr_cnt >= 4'd8)
						r = check_ws_length();
				end
			end
			PH_MASK: begin
				mask_key[hdr_cnt[1:0]] = b;
				hdr_cnt = hdr_cnt + 4'd1;
				if (hdr_cnt >= 4'd4)
					r = start_payload();
			end
			PH_PAYLOAD: begin
				r.kind = KIND_PAYLOAD;
				r.payload_byte = b ^ mask_key[mask_idx];
				mask_idx = mask_idx + 2'd1;
				remain = remain - 32'd1;
				r.last_of_message = (remain == 32'd0);
				r.message_length = len_acc;
				if (remain == 32'd0)
					go_idle();
			end
			default: begin
				hdr_cnt = '0;
				if (mode_reg == MODE_SHORT || mode_reg == MODE_LONG) begin
					len_acc = {24'd0, b};
					hdr_cnt = 4'd1;
					ph = PH_PREFIX;
				end else if (b == WS_OPCODE_TEXT) begin
					ph = PH_WS_SECOND;
				end else begin
					go_idle();
					r.kind = KIND_ERROR;
				end
			end
		endcase
		return r;
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		result_t r;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			repeat (gap) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				s_tdata <= 8'($urandom_range(0, 255));
			end
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= b;
		@(posedge clk);
		while (s_tready !== 1'b1)
			@(posedge clk);
		r = deframe_byte(b);
		deframed_q.push_back(r);
	endtask

	task automatic send_frame();
		foreach (frame_q[i])
			send_byte(frame_q[i]);
		frame_q.delete();
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (deframed_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [23:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		cfg_wdata <= 24'($urandom_range(0, 16777215));
		if (idx == REG_FRAME_MODE)
			mode_reg = val[1:0];
		else
			max_len_reg = val;
	endtask

	// Length encodings are picked at random, so short lengths often use the wider forms.
	task automatic build_ws_frame(input logic [31:0] len);
		int enc;
		bit zero_key;
		enc = (len > 32'd125) ? $urandom_range(2, 3) : $urandom_range(0, 3);
		zero_key = ($urandom_range(0, 7) == 0);
		frame_q.push_back(WS_OPCODE_TEXT);
		if (enc < 2) begin
			frame_q.push_back({1'b1, len[6:0]});
		end else if (enc == 2) begin
			frame_q.push_back(WS_LEN16_BYTE);
			frame_q.push_back(len[15:8]);
			frame_q.push_back(len[7:0]);
		end else begin
			frame_q.push_back(WS_LEN64_BYTE);
			repeat (4) frame_q.push_back(8'h00);
			frame_q.push_back(len[31:24]);
			frame_q.push_back(len[23:16]);
			frame_q.push_back(len[15:8]);
			frame_q.push_back(len[7:0]);
		end
		repeat (4) frame_q.push_back(zero_key ? 8'h00 : 8'($urandom_range(0, 255)));
		repeat (len) frame_q.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic run_phase(input logic [1:0] mode, input logic [23:0] max_len, input int n_items);
		int sent;
		int pick;
		logic [31:0] len;
		logic [7:0] b;
		wait_drained();
		write_reg(REG_FRAME_MODE, {22'd0, mode});
		write_reg(REG_MAX_LENGTH, max_len);
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(0, 99);
			if (mode_reg == MODE_SHORT || mode_reg == MODE_LONG) begin
				len = ($urandom_range(0, 9) == 0) ? 32'd0 : 32'($urandom_range(1, 40));
				if ($urandom_range(0, 19) == 0)
					len = 32'($urandom_range(200, 300));
				if (mode_reg == MODE_LONG) begin
					frame_q.push_back(len[31:24]);
					frame_q.push_back(len[23:16]);
				end
				frame_q.push_back(len[15:8]);
				frame_q.push_back(len[7:0]);
				repeat (len) frame_q.push_back(8'($urandom_range(0, 255)));
			end else if (pick < 70) begin
				len = ($urandom_range(0, 7) == 0) ? 32'd0 : 32'($urandom_range(1, 40));
				if (max_len_reg <= 24'd300 && $urandom_range(0, 15) == 0)
					len = {8'd0, max_len_reg};
				build_ws_frame(len);
			end else if (pick < 85) begin
				frame_q.push_back(WS_OPCODE_TEXT);
				case ($urandom_range(0, 2))
					0: begin
						frame_q.push_back({1'b0, 7'($urandom_range(0, 127))});
					end
					1: begin
						frame_q.push_back(WS_LEN64_BYTE);
						repeat ($urandom_range(0, 3)) frame_q.push_back(8'h00);
						frame_q.push_back(8'($urandom_range(1, 255)));
					end
					default: begin
						len = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF
							: {8'd0, max_len_reg} + 32'd1 + 32'($urandom_range(0, 3));
						if (len <= 32'd65535 && $urandom_range(0, 1) == 0) begin
							frame_q.push_back(WS_LEN16_BYTE);
						end else begin
							frame_q.push_back(WS_LEN64_BYTE);
							repeat (4) frame_q.push_back(8'h00);
							frame_q.push_back(len[31:24]);
							frame_q.push_back(len[23:16]);
						end
						frame_q.push_back(len[15:8]);
						frame_q.push_back(len[7:0]);
					end
				endcase
			end else begin
				b = 8'($urandom_range(0, 255));
				while (b == WS_OPCODE_TEXT)
					b = 8'($urandom_range(0, 255));
				frame_q.push_back(b);
			end
			sent += frame_q.size();
			send_frame();
		end
	endtask

	// Runs at reset values: bad opcode, mask bit clear, nonzero upper length byte,
	// an empty masked frame, and then a length just above a lowered maximum.
	task automatic test_ws_special_cases();
		frame_q = '{8'h00, 8'h81, 8'h7F, 8'h81, 8'hFF, 8'h01,
			8'h81, 8'h80, 8'h00, 8'hFF, 8'h5A, 8'hA5};
		send_frame();
		wait_drained();
		write_reg(REG_MAX_LENGTH, MAX_LENGTH_LOW);
		frame_q = '{8'h81, 8'hFE, 8'h00, 8'h81};
		send_frame();
	endtask

	// The long prefix is cut short by switching to the short mode between its bytes.
	task automatic test_prefix_modes();
		wait_drained();
		write_reg(REG_FRAME_MODE, {22'd0, MODE_SHORT});
		frame_q = '{8'h00, 8'h00};
		send_frame();
		wait_drained();
		write_reg(REG_FRAME_MODE, {22'd0, MODE_LONG});
		frame_q = '{8'h00, 8'h00};
		send_frame();
		wait_drained();
		write_reg(REG_FRAME_MODE, {22'd0, MODE_SHORT});
		frame_q = '{8'h01, 8'hFF};
		send_frame();
		wait_drained();
		write_reg(REG_FRAME_MODE, {22'd0, MODE_UNUSED});
		frame_q = '{8'h02};
		send_frame();
	endtask

	task automatic test_backpressure();
		wait_drained();
		write_reg(REG_FRAME_MODE, {22'd0, MODE_WEBSOCKET});
		write_reg(REG_MAX_LENGTH, MAX_LENGTH_TOP);
		holdoff_request = 60;
		build_ws_frame(32'd40);
		send_frame();
		wait_drained();
		build_ws_frame(32'd12);
		send_frame();
	endtask

	task automatic test_random_traffic();
		run_phase(MODE_WEBSOCKET, MAX_LENGTH_TOP, 250);
		run_phase(MODE_SHORT, MAX_LENGTH_TOP, 150);
		run_phase(MODE_LONG, 24'd1000, 150);
		run_phase(MODE_WEBSOCKET, MAX_LENGTH_LOW, 200);
		run_phase(MODE_UNUSED, 24'($urandom_range(129, 300)), 200);
		idle_on = 1'b0;
		run_phase(MODE_WEBSOCKET, 24'd200, 250);
	endtask

	initial begin : receiver
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (holdoff_request > 0) begin
				hold_left = holdoff_request;
				holdoff_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (idle_on && stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 4);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_result
		result_t seen;
		result_t want;
		if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
			seen.kind = m_tuser;
			seen.payload_byte = m_tdata[7:0];
			seen.last_of_message = m_tlast;
			seen.message_length = m_tdata[39:8];
			if (deframed_q.size() == 0) begin
				if (mismatch_count < REPORT_LIMIT)
					$display("%0t: unexpected transaction, expected none, actual kind %0d byte %h last %b length %0d",
						$time, seen.kind, seen.payload_byte, seen.last_of_message, seen.message_length);
				mismatch_count++;
			end else begin
				want = deframed_q.pop_front();
				if (seen !== want) begin
					if (mismatch_count < REPORT_LIMIT)
						$display("%0t: expected kind %0d byte %h last %b length %0d, actual kind %0d byte %h last %b length %0d",
							$time, want.kind, want.payload_byte, want.last_of_message, want.message_length,
							seen.kind, seen.payload_byte, seen.last_of_message, seen.message_length);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_ws_special_cases();
		test_prefix_modes();
		test_backpressure();
		test_random_traffic();
		wait_drained();
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
